>>> src/ecr_pkg.sv
// Shared types and constants for the elastic collision response pipeline.
// No dependencies; the stage modules, the top level and the test package import it.
package ecr_pkg;

	localparam int VW   = 32;            // Q16.16 vector component width
	localparam int MW   = 32;            // Q24.8 mass width
	localparam int QW   = 35;            // quotient bits per divide
	localparam int DENW = 64;            // divisor / remainder width
	localparam int NUMW = DENW + QW;     // dividend width

	localparam logic [MW-1:0] HOLD_MASS_RST = MW'(256000000);

	typedef logic [2:0][VW-1:0] vec3_t;

	// one input request as it enters the pipeline
	typedef struct packed {
		vec3_t          va;
		vec3_t          vb;
		vec3_t          pen;
		logic [MW-1:0]  mass_a;
		logic [MW-1:0]  mass_b;
		logic [1:0]     held_flags;
	} pair_t;

	// side data that travels alongside the arithmetic of one request
	typedef struct packed {
		vec3_t              va;
		vec3_t              vb;
		logic [2:0]         pneg;
		logic               hit;
		logic [MW-1:0]      ma;
		logic [MW-1:0]      mb;
		logic [MW:0]        total;
		logic [2:0][QW-1:0] ax;
	} side_t;

	typedef struct packed {
		logic [2:0][NUMW-1:0] num;
		logic [DENW-1:0]      den;
		side_t                side;
	} div_in_t;

	typedef struct packed {
		logic [2:0][QW-1:0]   q;
		logic [2:0][DENW-1:0] rem;
		side_t                side;
	} div_out_t;

	typedef struct packed {
		vec3_t nva;
		vec3_t nvb;
		logic  collided;
	} resp_t;

endpackage

>>> src/ecr_if.sv
// Handshake channels of the collision response block: the sphere pair request
// and the updated velocity response. Plain valid/ready with flat payload.
interface ecr_pair_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vel_a_x;
	logic signed [31:0] vel_a_y;
	logic signed [31:0] vel_a_z;
	logic signed [31:0] vel_b_x;
	logic signed [31:0] vel_b_y;
	logic signed [31:0] vel_b_z;
	logic signed [31:0] pen_x;
	logic signed [31:0] pen_y;
	logic signed [31:0] pen_z;
	logic [31:0]        mass_a;
	logic [31:0]        mass_b;
	logic [1:0]         held_flags;

	modport source (output valid, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
		pen_x, pen_y, pen_z, mass_a, mass_b, held_flags, input ready);
	modport sink (input valid, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
		pen_x, pen_y, pen_z, mass_a, mass_b, held_flags, output ready);
endinterface

interface ecr_resp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_vel_a_x;
	logic signed [31:0] new_vel_a_y;
	logic signed [31:0] new_vel_a_z;
	logic signed [31:0] new_vel_b_x;
	logic signed [31:0] new_vel_b_y;
	logic signed [31:0] new_vel_b_z;
	logic               collided;

	modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_a_z, new_vel_b_x,
		new_vel_b_y, new_vel_b_z, collided, input ready);
	modport sink (input valid, new_vel_a_x, new_vel_a_y, new_vel_a_z, new_vel_b_x,
		new_vel_b_y, new_vel_b_z, collided, output ready);
endinterface

>>> src/ecr_front.sv
// Front stages: mass select, relative velocity, dot product, |pen|^2 and
// the axial dividend. Six register stages. Depends on ecr_pkg.
module ecr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  ecr_pkg::pair_t     in_d,
	input  logic [ecr_pkg::MW-1:0] hold_mass,
	output logic               out_v,
	output ecr_pkg::div_in_t   out_d
);
	import ecr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	side_t              side_c, side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t              side4_c;
	vec3_t              pen_s1;
	logic [2:0][VW:0]   rel_c, rel_s1;
	logic [2:0][VW:0]   relm_s2;
	logic [2:0][VW-1:0] pm_s2, pm_s3, pm_s4;
	logic [2:0]         nsg_s2, nsg_s3;
	logic [2:0][64:0]   prod_s3;
	logic [2:0][63:0]   pp_s3;
	logic [64:0]        d_s4;
	logic [63:0]        p2_s4, p2_s5;
	logic [2:0][64:0]   pplo_s5;
	logic [2:0][63:0]   pphi_s5;
	logic signed [66:0] dsum_c;
	logic [65:0]        p2sum_c;

	// stage 1: select masses, form the relative velocity
	always_comb begin
		side_c       = '0;
		side_c.va    = in_d.va;
		side_c.vb    = in_d.vb;
		side_c.ma    = in_d.held_flags[0] ? hold_mass : in_d.mass_a;
		side_c.mb    = in_d.held_flags[1] ? hold_mass : in_d.mass_b;
		side_c.total = (MW+1)'(side_c.ma) + (MW+1)'(side_c.mb);
		for (int i = 0; i < 3; i++) begin
			side_c.pneg[i] = in_d.pen[i][VW-1];
			rel_c[i] = {in_d.va[i][VW-1], in_d.va[i]} - {in_d.vb[i][VW-1], in_d.vb[i]};
		end
	end

	// stage 4 sums and the approach test
	always_comb begin
		dsum_c  = '0;
		p2sum_c = '0;
		for (int i = 0; i < 3; i++) begin
			if (nsg_s3[i])
				dsum_c = dsum_c - $signed({2'b00, prod_s3[i]});
			else
				dsum_c = dsum_c + $signed({2'b00, prod_s3[i]});
			p2sum_c = p2sum_c + 66'(pp_s3[i]);
		end
		side4_c     = side_s3;
		side4_c.hit = dsum_c > 67'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			out_v <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			pen_s1  <= in_d.pen;
			rel_s1  <= rel_c;

			// stage 2: magnitudes and product signs
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) begin
				relm_s2[i] <= rel_s1[i][VW] ? (VW+1)'(~rel_s1[i] + 1'b1) : rel_s1[i];
				pm_s2[i]   <= pen_s1[i][VW-1] ? VW'(~pen_s1[i] + 1'b1) : pen_s1[i];
				nsg_s2[i]  <= rel_s1[i][VW] != pen_s1[i][VW-1];
			end

			// stage 3: products
			side_s3 <= side_s2;
			pm_s3   <= pm_s2;
			nsg_s3  <= nsg_s2;
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= 65'(relm_s2[i]) * 65'(pm_s2[i]);
				pp_s3[i]   <= 64'(pm_s2[i]) * 64'(pm_s2[i]);
			end

			// stage 4: dot product and approach test
			side_s4     <= side4_c;
			pm_s4       <= pm_s3;
			d_s4        <= dsum_c[64:0];
			p2_s4       <= p2sum_c[63:0];

			// stage 5: d * |pen_i| in two partial products
			side_s5 <= side_s4;
			p2_s5   <= p2_s4;
			for (int i = 0; i < 3; i++) begin
				pplo_s5[i] <= 65'(d_s4[32:0]) * 65'(pm_s4[i]);
				pphi_s5[i] <= 64'(d_s4[64:33]) * 64'(pm_s4[i]);
			end

			// stage 6: combine and add half the divisor for rounding
			out_d.side <= side_s5;
			out_d.den  <= p2_s5;
			for (int i = 0; i < 3; i++)
				out_d.num[i] <= NUMW'((97'(pphi_s5[i]) << 33) + 97'(pplo_s5[i])
					+ 97'(p2_s5 >> 1));
		end
	end

endmodule

>>> src/ecr_div.sv
// Pipelined restoring divider, three lanes over one shared divisor, one
// quotient bit per stage. Side data travels with each lane. Depends on ecr_pkg.
module ecr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  ecr_pkg::div_in_t  in_d,
	output logic              out_v,
	output ecr_pkg::div_out_t out_d
);
	import ecr_pkg::*;

	typedef struct packed {
		logic [DENW-1:0] rem;
		logic [QW-1:0]   lo;
	} step_t;

	// shift in the next dividend bit; quotient bits replace it from below
	function automatic step_t div_step(input logic [DENW-1:0] rem, input logic [QW-1:0] lo,
			input logic [DENW-1:0] den);
		logic [DENW:0] t;
		logic [DENW:0] diff;
		logic          ge;
		step_t         r;
		t      = {rem, lo[QW-1]};
		diff   = t - {1'b0, den};
		ge     = t >= {1'b0, den};
		r.rem  = ge ? diff[DENW-1:0] : t[DENW-1:0];
		r.lo   = {lo[QW-2:0], ge};
		return r;
	endfunction

	logic [2:0][DENW-1:0] rem_s  [QW];
	logic [2:0][QW-1:0]   lo_s   [QW];
	logic [DENW-1:0]      den_s  [QW];
	side_t                side_s [QW];
	logic [QW-1:0]        v_s;
	step_t                nxt    [QW][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nxt[0][i] = div_step(in_d.num[i][NUMW-1:QW], in_d.num[i][QW-1:0], in_d.den);
			for (int k = 1; k < QW; k++)
				nxt[k][i] = div_step(rem_s[k-1][i], lo_s[k-1][i], den_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[QW-2:0], in_v};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= in_d.den;
			side_s[0] <= in_d.side;
			for (int k = 1; k < QW; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < QW; k++) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= nxt[k][i].rem;
					lo_s[k][i]  <= nxt[k][i].lo;
				end
			end
		end
	end

	assign out_v      = v_s[QW-1];
	assign out_d.q    = lo_s[QW-1];
	assign out_d.rem  = rem_s[QW-1];
	assign out_d.side = side_s[QW-1];

endmodule

>>> src/ecr_scale.sv
// Mass weighting: axial part times twice the other mass, plus half the total
// for rounding, as the dividend of the second divide. Depends on ecr_pkg.
module ecr_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  ecr_pkg::div_out_t in_d,
	output logic              out_v,
	output ecr_pkg::div_in_t  out_d
);
	import ecr_pkg::*;

	logic              v_s1;
	side_t             side_c;
	side_t             side_s1;
	logic [2:0][67:0]  prod_s1;

	// keep the axial quotient with the side data for the final stages
	always_comb begin
		side_c    = in_d.side;
		side_c.ax = in_d.q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			out_v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= 68'(in_d.q[i]) * 68'({in_d.side.mb, 1'b0});

			out_d.side <= side_s1;
			out_d.den  <= DENW'(side_s1.total);
			for (int i = 0; i < 3; i++)
				out_d.num[i] <= NUMW'(69'(prod_s1[i]) + 69'(side_s1.total >> 1));
		end
	end

endmodule

>>> src/ecr_apply.sv
// Final stages: derive both velocity changes from one quotient, apply signs,
// add, saturate and select the pass-through case. Depends on ecr_pkg.
module ecr_apply (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  ecr_pkg::div_out_t in_d,
	output logic              out_v,
	output ecr_pkg::resp_t    out_d
);
	import ecr_pkg::*;

	function automatic logic [VW-1:0] sat32(input logic signed [38:0] x);
		if (x > 39'sd2147483647)
			return 32'h7fff_ffff;
		else if (x < -39'sd2147483648)
			return 32'h8000_0000;
		else
			return x[VW-1:0];
	endfunction

	// widen and combine one velocity component with its signed change
	function automatic logic [38:0] ta_of(input logic [VW-1:0] v, input logic [37:0] dv,
			input logic sub);
		logic [38:0] a;
		logic [38:0] b;
		a = {{7{v[VW-1]}}, v};
		b = {dv[37], dv};
		return sub ? a - b : a + b;
	endfunction

	logic             v_s1;
	side_t            side_s1;
	logic [2:0][37:0] sda_s1, sdb_s1;
	logic [2:0][36:0] db_c;
	logic [2:0]       tie_c;
	logic             upd;
	resp_t            resp_c;

	// B's change is 2*ax minus A's, plus one when A's quotient was an exact tie
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tie_c[i] = !in_d.side.total[0] && (in_d.rem[i] == '0);
			db_c[i]  = 37'({in_d.side.ax[i], 1'b0}) - 37'(in_d.q[i]) + 37'(tie_c[i]);
		end
	end

	assign upd = side_s1.hit && (side_s1.total != '0);

	// pass both velocities through unless the spheres approach and carry mass
	always_comb begin
		resp_c.nva      = side_s1.va;
		resp_c.nvb      = side_s1.vb;
		resp_c.collided = side_s1.hit;
		if (upd) begin
			for (int i = 0; i < 3; i++) begin
				resp_c.nva[i] = sat32($signed(ta_of(side_s1.va[i], sda_s1[i], 1'b1)));
				resp_c.nvb[i] = sat32($signed(ta_of(side_s1.vb[i], sdb_s1[i], 1'b0)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			out_v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_d.side;
			for (int i = 0; i < 3; i++) begin
				sda_s1[i] <= in_d.side.pneg[i] ? 38'(-38'(in_d.q[i])) : 38'(in_d.q[i]);
				sdb_s1[i] <= in_d.side.pneg[i] ? 38'(-38'(db_c[i])) : 38'(db_c[i]);
			end
			out_d <= resp_c;
		end
	end

endmodule

>>> src/elastic_collision_response.sv
// Top level of the two-sphere elastic collision response pipeline.
// Depends on ecr_pkg, ecr_if, ecr_front, ecr_div, ecr_scale and ecr_apply.
//
//   channel     | dir | handshake      | carries
//   ------------+-----+----------------+------------------------------------------
//   pair        | in  | valid / ready  | velocities A and B, pen, masses, held flags
//   resp        | out | valid / ready  | updated velocities A and B, collided
//   cfg         | in  | cfg_we         | held-sphere mass (Q24.8), no read-back
//
// One request enters per cycle while ready is high; from acceptance to
// resp.valid it passes 6 front stages, 35 + 35 divider stages (one quotient bit each),
// 2 weighting stages, 2 final stages and the output register.
// Reset clears all valid bits and loads the held-sphere mass with its default.
// A stalled response is held in the output register; one more result lands in
// a skid register, and only then does the whole pipeline freeze and drop ready.
module elastic_collision_response (
	input  logic                        clk,
	input  logic                        arst_n,
	ecr_pair_if.sink                    pair,
	ecr_resp_if.source                  resp,
	input  logic                        cfg_we,
	input  logic [ecr_pkg::MW-1:0]      cfg_wdata
);
	import ecr_pkg::*;

	logic [MW-1:0] hold_mass_q;
	pair_t         pair_d;
	logic          en;

	logic          front_v, ax_v, scale_v, dv_v, apply_v;
	div_in_t       front_d, scale_d;
	div_out_t      ax_d, dv_d;
	resp_t         apply_d;

	logic          push;
	logic          out_v_q, skid_v_q;
	resp_t         out_q, skid_q;

	// held-sphere mass register; the user must write it only while the block is idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_mass_q <= HOLD_MASS_RST;
		else if (cfg_we)
			hold_mass_q <= cfg_wdata;
	end

	assign pair_d.va         = {pair.vel_a_z, pair.vel_a_y, pair.vel_a_x};
	assign pair_d.vb         = {pair.vel_b_z, pair.vel_b_y, pair.vel_b_x};
	assign pair_d.pen        = {pair.pen_z, pair.pen_y, pair.pen_x};
	assign pair_d.mass_a     = pair.mass_a;
	assign pair_d.mass_b     = pair.mass_b;
	assign pair_d.held_flags = pair.held_flags;

	// advance every stage together unless the skid register is occupied
	assign en         = !skid_v_q;
	assign pair.ready = en;

	ecr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (pair.valid),
		.in_d      (pair_d),
		.hold_mass (hold_mass_q),
		.out_v     (front_v),
		.out_d     (front_d)
	);

	// axial part: round(d * |pen_i| / |pen|^2)
	ecr_div u_div_ax (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (front_v),
		.in_d   (front_d),
		.out_v  (ax_v),
		.out_d  (ax_d)
	);

	ecr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (ax_v),
		.in_d   (ax_d),
		.out_v  (scale_v),
		.out_d  (scale_d)
	);

	// A's velocity change: round(ax * 2 * mb / total); B's follows from it
	ecr_div u_div_dv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (scale_v),
		.in_d   (scale_d),
		.out_v  (dv_v),
		.out_d  (dv_d)
	);

	ecr_apply u_apply (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (dv_v),
		.in_d   (dv_d),
		.out_v  (apply_v),
		.out_d  (apply_d)
	);

	assign push = en && apply_v;

	// output register plus skid: drain the skid first, else take the new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && resp.ready) begin
			if (skid_v_q)
				skid_v_q <= 1'b0;
			else if (!push)
				out_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && resp.ready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (push)
				out_q <= apply_d;
		end else if (push) begin
			if (!out_v_q)
				out_q <= apply_d;
			else
				skid_q <= apply_d;
		end
	end

	assign resp.valid       = out_v_q;
	assign resp.new_vel_a_x = out_q.nva[0];
	assign resp.new_vel_a_y = out_q.nva[1];
	assign resp.new_vel_a_z = out_q.nva[2];
	assign resp.new_vel_b_x = out_q.nvb[0];
	assign resp.new_vel_b_y = out_q.nvb[1];
	assign resp.new_vel_b_z = out_q.nvb[2];
	assign resp.collided    = out_q.collided;

endmodule

>>> src/ecr_checker.sv
// Port-level checks for elastic_collision_response, attached by bind.
// Depends only on the top level's ports.
module ecr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pair_ready,
	input logic        resp_valid,
	input logic        resp_ready,
	input logic        resp_collided,
	input logic [31:0] resp_vel_a_x,
	input logic [31:0] resp_vel_b_x
);

	// a pending response stays offered
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid)
		else $error("response withdrawn while stalled");

	// a pending response keeps its collided flag and both x velocities
	a_resp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> $stable(resp_collided) && $stable(resp_vel_a_x)
			&& $stable(resp_vel_b_x))
		else $error("response payload changed while stalled");

	// requests are refused only while a result is backed up at the output
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> resp_valid)
		else $error("request refused with no result pending");

	// ready drops only after the output was stalled
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pair_ready) |-> $past(resp_valid && !resp_ready))
		else $error("ready dropped without an output stall");

	// ready returns only after a result was taken
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pair_ready) |-> $past(resp_valid && resp_ready))
		else $error("ready returned without a result taken");

endmodule

bind elastic_collision_response ecr_checker u_ecr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pair_ready    (pair.ready),
	.resp_valid    (resp.valid),
	.resp_ready    (resp.ready),
	.resp_collided (resp.collided),
	.resp_vel_a_x  (resp.new_vel_a_x),
	.resp_vel_b_x  (resp.new_vel_b_x)
);

>>> test/ecr_test_if.sv
`timescale 1ns / 1ps
// Test-side request and response records for the elastic_collision_response
// bench; the block's own channel interfaces are in src/ecr_if.sv.
// Depends on ecr_pkg.
package ecr_test_pkg;
	import ecr_pkg::*;

	// one sphere pair request as the test sees it
	typedef struct {
		logic signed [31:0] va[3];
		logic signed [31:0] vb[3];
		logic signed [31:0] pen[3];
		logic [31:0]        ma;
		logic [31:0]        mb;
		logic [1:0]         held;
	} pair_req_t;

	typedef struct {
		logic signed [31:0] nva[3];
		logic signed [31:0] nvb[3];
		logic               collided;
	} resp_val_t;
endpackage

>>> test/elastic_collision_response_test.sv
`timescale 1ns / 1ps
// Regression bench for elastic_collision_response: directed and random sphere
// pairs with a bit-exact predictor. Depends on ecr_pkg, ecr_if, ecr_test_pkg and the top level.
module elastic_collision_response_test;
	import ecr_pkg::*;
	import ecr_test_pkg::*;

	localparam int LATENCY    = 81;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	ecr_pair_if pair ();
	ecr_resp_if resp ();

	elastic_collision_response i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.resp      (resp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pair_req_t pending_q[$];      // requests waiting to be driven
	resp_val_t expected_q[$];     // predicted responses, oldest first
	logic [31:0] held_mass = HOLD_MASS_RST;
	int  fail_count = 0;
	int  idle_cycles = 0;
	bit  idling_on = 1'b1;        // random gaps on both sides when set
	bit  drive_hold = 1'b0;       // hold the sender off
	bit  stim_done = 1'b0;

	// round(num / den), ties away from zero; den nonzero
	function automatic logic [255:0] div_round(logic [255:0] num, logic [255:0] den);
		return (num + (den >> 1)) / den;
	endfunction

	function automatic logic signed [31:0] saturate(logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		if (v < -66'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// compute the collision response of one pair
	function automatic resp_val_t collide(pair_req_t p, logic [31:0] mmax);
		resp_val_t r;
		logic [31:0] ma, mb;
		logic [32:0] total;
		logic signed [127:0] dot;
		logic [255:0] dmag, p2, ax, da, db, pm;
		logic signed [65:0] rel, dv;
		dot = 0;
		p2 = 0;
		ma = p.held[0] ? mmax : p.ma;
		mb = p.held[1] ? mmax : p.mb;
		total = {1'b0, ma} + {1'b0, mb};
		for (int i = 0; i < 3; i++) begin
			rel = 66'(p.va[i]) - 66'(p.vb[i]);
			dot += 128'(rel) * 128'(p.pen[i]);
			pm = p.pen[i] < 0 ? 256'(-66'(p.pen[i])) : 256'(p.pen[i]);
			p2 += pm * pm;
			r.nva[i] = p.va[i];
			r.nvb[i] = p.vb[i];
		end
		r.collided = dot > 0;
		if (r.collided && total != 0) begin
			dmag = 256'(dot);
			for (int i = 0; i < 3; i++) begin
				pm = p.pen[i] < 0 ? 256'(-66'(p.pen[i])) : 256'(p.pen[i]);
				ax = div_round(dmag * pm, p2);
				ax = ax[63:0];
				da = div_round(ax * (256'(mb) << 1), 256'(total));
				db = div_round(ax * (256'(ma) << 1), 256'(total));
				dv = 66'(signed'(da[63:0]));
				if (p.pen[i] < 0)
					dv = -dv;
				r.nva[i] = saturate(66'(p.va[i]) - dv);
				dv = 66'(signed'(db[63:0]));
				if (p.pen[i] < 0)
					dv = -dv;
				r.nvb[i] = saturate(66'(p.vb[i]) + dv);
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_edge32();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return 32'hffffffff;
			4: return 32'(signed'($urandom_range(0, 8191) - 4096) <<< 16);
			5: return 32'(signed'($urandom_range(0, 2000) - 1000));
			default: return $urandom;
		endcase
	endfunction

	function automatic pair_req_t rand_pair();
		pair_req_t p;
		logic signed [31:0] s;
		for (int i = 0; i < 3; i++) begin
			p.va[i] = rand_edge32();
			p.vb[i] = rand_edge32();
			p.pen[i] = rand_edge32();
		end
		// mostly approaching pairs: set A's velocity to B's plus a quarter of pen
		if ($urandom_range(0, 99) < 60) begin
			for (int i = 0; i < 3; i++) begin
				s = 32'(signed'($urandom_range(0, 65535) - 32768) <<< 4);
				p.pen[i] = s;
				p.va[i] = p.vb[i] + (s >>> 2);
			end
		end
		case ($urandom_range(0, 5))
			0: p.ma = 0;
			1: p.ma = 32'hffffffff;
			default: p.ma = $urandom_range(1, 1 << 20);
		endcase
		case ($urandom_range(0, 5))
			0: p.mb = 0;
			1: p.mb = 32'hffffffff;
			default: p.mb = $urandom;
		endcase
		p.held = $urandom_range(0, 3);
		return p;
	endfunction

	function automatic pair_req_t make_pair(int a, int b, int pn, int m1, int m2, int h);
		pair_req_t p;
		for (int i = 0; i < 3; i++) begin
			p.va[i] = a;
			p.vb[i] = b;
			p.pen[i] = pn;
		end
		p.ma = m1;
		p.mb = m2;
		p.held = h;
		return p;
	endfunction

	// driver: advance to the next request after each handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair.valid <= 1'b0;
		end else begin
			if (pair.valid && pair.ready) begin
				expected_q.push_back(collide(pending_q.pop_front(), held_mass));
			end
			if (pending_q.size() > (pair.valid && pair.ready ? 1 : 0) - 0
				&& pending_q.size() != 0 && !drive_hold
				&& !(idling_on && $urandom_range(0, 99) < 17)) begin
				pair.valid <= 1'b1;
				pair.vel_a_x <= pending_q[0].va[0];
				pair.vel_a_y <= pending_q[0].va[1];
				pair.vel_a_z <= pending_q[0].va[2];
				pair.vel_b_x <= pending_q[0].vb[0];
				pair.vel_b_y <= pending_q[0].vb[1];
				pair.vel_b_z <= pending_q[0].vb[2];
				pair.pen_x <= pending_q[0].pen[0];
				pair.pen_y <= pending_q[0].pen[1];
				pair.pen_z <= pending_q[0].pen[2];
				pair.mass_a <= pending_q[0].ma;
				pair.mass_b <= pending_q[0].mb;
				pair.held_flags <= pending_q[0].held;
			end else if (!pair.valid || pair.ready) begin
				pair.valid <= 1'b0;
			end
		end
	end

	// monitor: compare each response with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		resp_val_t e;
		logic [31:0] got[7], want[7];
		if (!arst_n) begin
			resp.ready <= 1'b0;
		end else begin
			if (resp.valid && resp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %h %h %h",
						$time, resp.new_vel_a_x, resp.new_vel_b_x, resp.collided);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					got = '{resp.new_vel_a_x, resp.new_vel_a_y, resp.new_vel_a_z,
						resp.new_vel_b_x, resp.new_vel_b_y, resp.new_vel_b_z,
						32'(resp.collided)};
					want = '{e.nva[0], e.nva[1], e.nva[2], e.nvb[0], e.nvb[1], e.nvb[2],
						32'(e.collided)};
					for (int i = 0; i < 7; i++) begin
						if (got[i] !== want[i]) begin
							$display("%0t: field %0d mismatch, expected %h, actual %h",
								$time, i, want[i], got[i]);
							fail_count++;
						end
					end
				end
			end
			resp.ready <= !(idling_on && $urandom_range(0, 99) < 17);
		end
	end

	// watchdog: count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((pair.valid && pair.ready) || (resp.valid && resp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("elastic_collision_response regression: fail");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_q.size() == 0 && !pair.valid && expected_q.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_hold_mass(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		held_mass = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			pending_q.push_back(rand_pair());
	endtask

	initial begin
		pair.vel_a_x = 0; pair.vel_a_y = 0; pair.vel_a_z = 0;
		pair.vel_b_x = 0; pair.vel_b_y = 0; pair.vel_b_z = 0;
		pair.pen_x = 0; pair.pen_y = 0; pair.pen_z = 0;
		pair.mass_a = 0; pair.mass_b = 0; pair.held_flags = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero pen, separating, zero total mass, extremes, held flags
		pending_q.push_back(make_pair(65536, 0, 0, 256, 256, 0));
		pending_q.push_back(make_pair(0, 65536, 65536, 256, 256, 0));
		pending_q.push_back(make_pair(65536, 65536, 65536, 256, 256, 0));
		pending_q.push_back(make_pair(65536, 0, 65536, 256, 256, 0));
		pending_q.push_back(make_pair(65536, 0, 65536, 0, 0, 0));
		pending_q.push_back(make_pair(-65536, 0, -65536, 0, 512, 0));
		pending_q.push_back(make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'hffffffff, 1, 0));
		pending_q.push_back(make_pair(32'h80000000, 32'h7fffffff, 32'h80000000,
			1, 32'hffffffff, 0));
		pending_q.push_back(make_pair(32'h7fffffff, 32'h80000000, 1, 0, 32'hffffffff, 3));
		pending_q.push_back(make_pair(131072, -65536, 32768, 100, 300, 1));
		pending_q.push_back(make_pair(131072, -65536, 32768, 100, 300, 2));
		pending_q.push_back(make_pair(131072, -65536, 32768, 100, 300, 3));
		pending_q.push_back(make_pair(-1, 0, -1, 32'hffffffff, 32'hffffffff, 0));
		random_phase(300);

		// sender pause mid-batch: hold off until every response is back
		wait (pending_q.size() <= 150);
		drive_hold = 1'b1;
		wait (expected_q.size() == 0 && !pair.valid);
		repeat (LATENCY + 5) @(posedge clk);
		drive_hold = 1'b0;

		write_hold_mass(32'h0);
		random_phase(300);
		write_hold_mass(32'hffffffff);
		idling_on = 1'b0;           // long stretch at full rate
		random_phase(300);
		drain();
		idling_on = 1'b1;
		write_hold_mass($urandom);
		random_phase(300);
		write_hold_mass(HOLD_MASS_RST);
		random_phase(330);

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("elastic_collision_response regression: pass");
		else
			$display("elastic_collision_response regression: fail");
		$finish;
	end
endmodule
